// File: rtl/core/lrdp_pkg.sv
// Shared types and codes for the log ring with dump and prune requests.
`timescale 1ns / 1ps
`default_nettype none

package lrdp_pkg;

   // Request codes
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_DUMP   = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   // Result kinds
   localparam logic KIND_LINE = 1'b0;
   localparam logic KIND_ACK  = 1'b1;

   // Width of the line number and line total fields
   localparam int LINE_W = 7;

   typedef struct packed {
      logic [1:0]        op;
      logic [31:0]       time_sec;
      logic [29:0]       time_nsec;
      logic [7:0]        log_kind;
      logic [31:0]       route_id;
      logic [31:0]       source_node;
      logic [31:0]       requester_node;
   } req_type;

   typedef struct packed {
      logic              result_kind;
      logic [31:0]       destination_node;
      logic [LINE_W-1:0] line_number;
      logic [LINE_W-1:0] line_total;
      logic [31:0]       out_time_sec;
      logic [29:0]       out_time_nsec;
      logic [7:0]        out_kind;
      logic [31:0]       out_route;
      logic [31:0]       out_source;
      logic              last;
   } rsp_type;

   // One stored log line
   typedef struct packed {
      logic [31:0]       time_sec;
      logic [29:0]       time_nsec;
      logic [7:0]        log_kind;
      logic [31:0]       route_id;
      logic [31:0]       source_node;
   } line_type;

   // Result header built by the sequencer; has_line selects stored data
   typedef struct packed {
      logic              result_kind;
      logic [31:0]       destination_node;
      logic [LINE_W-1:0] line_number;
      logic [LINE_W-1:0] line_total;
      logic              last;
      logic              has_line;
   } meta_type;

endpackage

`default_nettype wire

// File: rtl/core/lrdp_store.sv
// Line memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lrdp_store #(
   parameter int LOG_DEPTH = 64,
   localparam int IDX_W = $clog2(LOG_DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [IDX_W-1:0]    wr_idx,
   input  wire lrdp_pkg::line_type  wr_line,
   input  wire logic                rd_en,
   input  wire logic [IDX_W-1:0]    rd_idx,
   output lrdp_pkg::line_type       rd_line
);
   import lrdp_pkg::*;

   line_type mem [LOG_DEPTH];
   line_type rd_line_ff;

   // Write on append; read data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_line;
      end
      if (rd_en) begin
         rd_line_ff <= mem[rd_idx];
      end
   end

   assign rd_line = rd_line_ff;

endmodule

`default_nettype wire

// File: rtl/core/lrdp_ctrl.sv
// Ring pointers, sent mark, dump sequencer and result header register.
`timescale 1ns / 1ps
`default_nettype none

module lrdp_ctrl #(
   parameter int LOG_DEPTH = 64,
   localparam int IDX_W = $clog2(LOG_DEPTH),
   localparam int CNT_W = $clog2(LOG_DEPTH + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire lrdp_pkg::req_type   req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output lrdp_pkg::meta_type       rsp_meta,
   output logic                     wr_en,
   output logic [IDX_W-1:0]         wr_idx,
   output lrdp_pkg::line_type       wr_line,
   output logic                     rd_en,
   output logic [IDX_W-1:0]         rd_idx
);
   import lrdp_pkg::*;

   localparam int SUM_W = CNT_W + 1;

   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             mark_valid_ff, mark_valid_in;
   logic [IDX_W-1:0] mark_idx_ff, mark_idx_in;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] num_ff, num_in;
   logic [31:0]      dest_ff, dest_in;
   logic             rsp_valid_ff, rsp_valid_in;
   meta_type         meta_ff, meta_in;

   logic             slot_free;
   logic             is_last;
   logic [IDX_W-1:0] append_slot;
   logic [IDX_W-1:0] newest_idx;
   logic [IDX_W-1:0] oldest_plus_count;
   logic [SUM_W-1:0] mark_dist;
   logic [SUM_W-1:0] removed;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
      logic [IDX_W-1:0] r;
      r = (x == IDX_W'(LOG_DEPTH - 1)) ? '0 : x + 1'b1;
      return r;
   endfunction

   // Fold a sum below twice the depth back into the ring
   function automatic logic [IDX_W-1:0] idx_wrap(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] r;
      r = (s >= SUM_W'(LOG_DEPTH)) ? s - SUM_W'(LOG_DEPTH) : s;
      return r[IDX_W-1:0];
   endfunction

   // Ring arithmetic shared by the request handlers
   always_comb begin
      oldest_plus_count = idx_wrap(SUM_W'(oldest_ff) + SUM_W'(count_ff));
      append_slot       = oldest_plus_count;
      newest_idx        = idx_wrap(SUM_W'(oldest_ff) + SUM_W'(count_ff) - SUM_W'(1));
      mark_dist         = SUM_W'(mark_idx_ff) - SUM_W'(oldest_ff)
                          + ((mark_idx_ff < oldest_ff) ? SUM_W'(LOG_DEPTH) : '0);
      removed           = mark_dist + SUM_W'(1);
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_last   = (num_ff == count_ff);

   // Accept requests, stream dump reads, update ring state
   always_comb begin
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      mark_valid_in = mark_valid_ff;
      mark_idx_in   = mark_idx_ff;
      busy_in       = busy_ff;
      rd_idx_in     = rd_idx_ff;
      num_in        = num_ff;
      dest_in       = dest_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      meta_in       = meta_ff;
      wr_en         = 1'b0;
      wr_idx        = append_slot;
      wr_line       = '{req_data.time_sec, req_data.time_nsec, req_data.log_kind,
                        req_data.route_id, req_data.source_node};
      rd_en         = 1'b0;
      req_ready     = 1'b0;

      if (busy_ff) begin
         // Issue one line read whenever the result slot frees up
         if (slot_free) begin
            rd_en        = 1'b1;
            rsp_valid_in = 1'b1;
            meta_in      = '{KIND_LINE, dest_ff, LINE_W'(num_ff), LINE_W'(count_ff),
                             is_last, 1'b1};
            rd_idx_in    = idx_inc(rd_idx_ff);
            num_in       = num_ff + 1'b1;
            if (is_last) begin
               busy_in = 1'b0;
            end
         end
      end else begin
         req_ready = (req_data.op == OP_DUMP || req_data.op == OP_DELETE) ? slot_free : 1'b1;
         if (req_valid && req_ready) begin
            unique case (req_data.op)
               OP_APPEND: begin
                  wr_en = 1'b1;
                  if (count_ff < CNT_W'(LOG_DEPTH)) begin
                     count_in = count_ff + 1'b1;
                  end else begin
                     // Full: overwrite the oldest line, drop a mark on it
                     wr_idx    = oldest_ff;
                     oldest_in = idx_inc(oldest_ff);
                     if (mark_valid_ff && mark_idx_ff == oldest_ff) begin
                        mark_valid_in = 1'b0;
                     end
                  end
               end
               OP_DUMP: begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     meta_in       = '{KIND_LINE, req_data.requester_node, '0, '0,
                                       1'b1, 1'b0};
                     mark_valid_in = 1'b0;
                  end else begin
                     busy_in       = 1'b1;
                     rd_idx_in     = oldest_ff;
                     num_in        = CNT_W'(1);
                     dest_in       = req_data.requester_node;
                     mark_valid_in = 1'b1;
                     mark_idx_in   = newest_idx;
                  end
               end
               OP_DELETE: begin
                  if (mark_valid_ff) begin
                     // Prune up to the mark, saturating at the stored count
                     if (removed >= SUM_W'(count_ff)) begin
                        oldest_in = oldest_plus_count;
                        count_in  = '0;
                     end else begin
                        oldest_in = idx_inc(mark_idx_ff);
                        count_in  = count_ff - removed[CNT_W-1:0];
                     end
                     mark_valid_in = 1'b0;
                  end
                  rsp_valid_in = 1'b1;
                  meta_in      = '{KIND_ACK, req_data.requester_node, '0, '0, 1'b1, 1'b0};
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff     <= '0;
         count_ff      <= '0;
         mark_valid_ff <= 1'b0;
         mark_idx_ff   <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         oldest_ff     <= oldest_in;
         count_ff      <= count_in;
         mark_valid_ff <= mark_valid_in;
         mark_idx_ff   <= mark_idx_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Sequencer payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      num_ff    <= num_in;
      dest_ff   <= dest_in;
      meta_ff   <= meta_in;
   end

   assign rd_idx    = rd_idx_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_meta  = meta_ff;

endmodule

`default_nettype wire

// File: rtl/core/log_ring_dump_prune.sv
// Top level of the log ring: request and result channels around store and control.
// Usage:
//   Requests enter on req_valid/req_ready as req_data (append, dump, delete).
//   Results leave on rsp_valid/rsp_ready as rsp_data; last marks the final
//   result of a request.
//   An append gives no result; it is accepted even while
//   an earlier result still waits on the result channel.
//   A delete's acknowledgment is valid the cycle after acceptance.
//   A dump of N stored lines holds req_ready low while it streams: acceptance
//   sets the busy state, each line is then read into the memory's data register
//   with its header, and lines follow one per cycle while rsp_ready is high. An
//   empty store gives a single result in the cycle after acceptance.
//   The rate is set by the single read port of the line memory, one line read
//   per cycle, with its data register serving as the result register.
//   When rsp_ready is low the result holds and the dump pauses; dump and
//   delete requests are taken only when the result register is free.
//   Reset empties the ring and clears the sent mark; memory contents are not
//   cleared, since only written lines are ever read.
`timescale 1ns / 1ps
`default_nettype none

module log_ring_dump_prune #(
   parameter int LOG_DEPTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire lrdp_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output lrdp_pkg::rsp_type       rsp_data
);
   import lrdp_pkg::*;

   localparam int IDX_W = $clog2(LOG_DEPTH);

   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   line_type         wr_line;
   logic             rd_en;
   logic [IDX_W-1:0] rd_idx;
   line_type         rd_line;
   meta_type         rsp_meta;

   lrdp_ctrl #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_meta  (rsp_meta),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_line   (wr_line),
      .rd_en     (rd_en),
      .rd_idx    (rd_idx)
   );

   lrdp_store #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_line (wr_line),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_line (rd_line)
   );

   // Merge header with stored line; zero line fields on acks and empty dumps
   always_comb begin
      rsp_data.result_kind      = rsp_meta.result_kind;
      rsp_data.destination_node = rsp_meta.destination_node;
      rsp_data.line_number      = rsp_meta.line_number;
      rsp_data.line_total       = rsp_meta.line_total;
      rsp_data.last             = rsp_meta.last;
      if (rsp_meta.has_line) begin
         rsp_data.out_time_sec  = rd_line.time_sec;
         rsp_data.out_time_nsec = rd_line.time_nsec;
         rsp_data.out_kind      = rd_line.log_kind;
         rsp_data.out_route     = rd_line.route_id;
         rsp_data.out_source    = rd_line.source_node;
      end else begin
         rsp_data.out_time_sec  = '0;
         rsp_data.out_time_nsec = '0;
         rsp_data.out_kind      = '0;
         rsp_data.out_route     = '0;
         rsp_data.out_source    = '0;
      end
   end

endmodule

`default_nettype wire

// File: bench/tb_log_ring_dump_prune.sv
// Self-checking bench for the log ring: appends, dumps, deletes, ring overwrite.
`timescale 1ns / 1ps

module tb_log_ring_dump_prune;
   import lrdp_pkg::*;

   localparam int LOG_DEPTH    = 64;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 120;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int REPORT_MAX   = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Predicts the log ring and holds the results still owed by the block
   class log_ring_board;
      line_type ring[LOG_DEPTH];
      int       oldest;
      int       count;
      bit       mark_valid;
      int       mark_slot;
      rsp_type  owed[$];
      int       failures;
      int       checked;
      int       appends, dumps, deletes, ignored;
      int       longest_dump, mark_drops, full_dumps;

      function rsp_type make_result(logic kind, logic [31:0] dest, int num, int total,
                                    line_type ln, logic fin);
         rsp_type x;
         x.result_kind      = kind;
         x.destination_node = dest;
         x.line_number      = LINE_W'(num);
         x.line_total       = LINE_W'(total);
         x.out_time_sec     = ln.time_sec;
         x.out_time_nsec    = ln.time_nsec;
         x.out_kind         = ln.log_kind;
         x.out_route        = ln.route_id;
         x.out_source       = ln.source_node;
         x.last             = fin;
         return x;
      endfunction

      // Update the ring for one accepted item and queue what it must produce
      function void note_request(req_type r);
         line_type ln;
         int slot;
         int removed;
         case (r.op)
            OP_APPEND: begin
               appends++;
               if (count < LOG_DEPTH) begin
                  count++;
               end else begin
                  // discarding the marked line drops the mark
                  if (mark_valid && mark_slot == oldest) begin
                     mark_valid = 1'b0;
                     mark_drops++;
                  end
                  oldest = (oldest + 1) % LOG_DEPTH;
               end
               slot = (oldest + count - 1) % LOG_DEPTH;
               ring[slot] = '{r.time_sec, r.time_nsec, r.log_kind, r.route_id,
                              r.source_node};
            end
            OP_DUMP: begin
               dumps++;
               if (count == 0) begin
                  mark_valid = 1'b0;
                  owed.push_back(make_result(KIND_LINE, r.requester_node, 0, 0, '0,
                                             1'b1));
               end else begin
                  for (int i = 0; i < count; i++) begin
                     slot = (oldest + i) % LOG_DEPTH;
                     owed.push_back(make_result(KIND_LINE, r.requester_node, i + 1,
                                                count, ring[slot], i + 1 == count));
                  end
                  mark_valid = 1'b1;
                  mark_slot  = (oldest + count - 1) % LOG_DEPTH;
                  if (count > longest_dump) longest_dump = count;
                  if (count == LOG_DEPTH) full_dumps++;
               end
            end
            OP_DELETE: begin
               deletes++;
               // prune from the oldest line through the mark
               if (mark_valid) begin
                  removed = (mark_slot + LOG_DEPTH - oldest) % LOG_DEPTH + 1;
                  if (removed > count) removed = count;
                  oldest     = (oldest + removed) % LOG_DEPTH;
                  count      = count - removed;
                  mark_valid = 1'b0;
               end
               owed.push_back(make_result(KIND_ACK, r.requester_node, 0, 0, '0, 1'b1));
            end
            default: ignored++;
         endcase
      endfunction

      // Compare one accepted result against the oldest owed one
      function void check_result(rsp_type got);
         rsp_type want;
         string   bad;
         checked++;
         if (owed.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("result %0d arrived with nothing owed: got %h", checked, got);
            return;
         end
         want = owed.pop_front();
         bad = "";
         if (got.result_kind !== want.result_kind) bad = {bad, " result_kind"};
         if (got.destination_node !== want.destination_node) bad = {bad, " destination_node"};
         if (got.line_number !== want.line_number) bad = {bad, " line_number"};
         if (got.line_total !== want.line_total) bad = {bad, " line_total"};
         if (got.out_time_sec !== want.out_time_sec) bad = {bad, " out_time_sec"};
         if (got.out_time_nsec !== want.out_time_nsec) bad = {bad, " out_time_nsec"};
         if (got.out_kind !== want.out_kind) bad = {bad, " out_kind"};
         if (got.out_route !== want.out_route) bad = {bad, " out_route"};
         if (got.out_source !== want.out_source) bad = {bad, " out_source"};
         if (got.last !== want.last) bad = {bad, " last"};
         if (bad != "") begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("result %0d wrong in%s: expected %h, got %h", checked, bad,
                        want, got);
         end
      endfunction

      function int outstanding();
         return owed.size();
      endfunction
   endclass

   log_ring_board board = new();

   int cycle_count    = 0;
   int item_count     = 0;
   bit sender_steady  = 1'b0;
   int stall_left     = 0;
   int calm_left      = 0;
   bit long_hold_done = 1'b0;

   log_ring_dump_prune #(.LOG_DEPTH(LOG_DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Mostly short idle stretches, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic req_type random_line();
      req_type r;
      r.op             = OP_APPEND;
      r.time_sec       = $urandom;
      r.time_nsec      = 30'($urandom_range(999999999, 0));
      r.log_kind       = 8'($urandom_range(255, 0));
      r.route_id       = $urandom;
      r.source_node    = $urandom;
      r.requester_node = $urandom;
      return r;
   endfunction

   function automatic req_type ctl_req(logic [1:0] op, logic [31:0] requester);
      req_type r;
      r = random_line();
      r.op = op;
      r.requester_node = requester;
      return r;
   endfunction

   // Offer one item, hold it until accepted, then maybe idle
   task automatic send_req(input req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      board.note_request(r);
      if (r.op != OP_UNUSED) item_count++;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Result side: check accepted results and throttle rsp_ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         if (!long_hold_done && rsp_valid && rsp_data.line_total == LINE_W'(LOG_DEPTH)) begin
            // hold off through a full dump so the block backs up onto its input
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD;
         end else if (stall_left == 0 && calm_left > 0) begin
            calm_left--;
         end else if (stall_left == 0 && $urandom_range(7, 0) == 0) begin
            if ($urandom_range(4, 0) == 0) calm_left = $urandom_range(80, 20);
            else stall_left = ($urandom_range(99, 0) < 85) ? $urandom_range(3, 1)
                                                          : $urandom_range(40, 8);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results still owed", cycle_count,
                  board.outstanding());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : request_side
      req_type r;
      int      n;
      int      pick;
      int      directed_items;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty store, delete with no mark, unused op
      send_req(ctl_req(OP_DUMP, 32'h0000_0000));
      send_req(ctl_req(OP_DELETE, 32'hFFFF_FFFF));
      send_req(ctl_req(OP_UNUSED, $urandom));

      // Field extremes, then dump and prune them
      r = '0;
      r.op = OP_APPEND;
      send_req(r);
      r = '{OP_APPEND, 32'hFFFF_FFFF, 30'd999999999, 8'hFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF};
      send_req(r);
      send_req(ctl_req(OP_DUMP, 32'hFFFF_FFFF));
      send_req(ctl_req(OP_DELETE, 32'h0000_0000));
      send_req(ctl_req(OP_DUMP, $urandom));

      // Lines appended after a dump survive the delete
      repeat (3) send_req(random_line());
      send_req(ctl_req(OP_DUMP, $urandom));
      repeat (2) send_req(random_line());
      send_req(ctl_req(OP_DELETE, $urandom));
      send_req(ctl_req(OP_DUMP, $urandom));
      send_req(ctl_req(OP_DUMP, $urandom));
      send_req(ctl_req(OP_DELETE, $urandom));
      send_req(ctl_req(OP_DELETE, $urandom));
      r = random_line();
      r.op = OP_UNUSED;
      send_req(r);

      // Mark a single line, then fill the ring until that line is overwritten
      send_req(random_line());
      send_req(ctl_req(OP_DUMP, $urandom));
      directed_items = item_count;
      sender_steady = 1'b1;
      repeat (LOG_DEPTH) send_req(random_line());
      sender_steady = 1'b0;
      send_req(ctl_req(OP_DELETE, $urandom));
      send_req(ctl_req(OP_DUMP, $urandom));
      send_req(ctl_req(OP_DELETE, $urandom));
      send_req(random_line());
      send_req(ctl_req(OP_DUMP, $urandom));
      send_req(ctl_req(OP_DELETE, $urandom));

      // Random sequences: mostly append-dump-delete runs, some bursts and noise
      while (item_count < directed_items + RANDOM_ITEMS) begin
         sender_steady = ($urandom_range(3, 0) == 0);
         pick = $urandom_range(11, 0);
         if (pick <= 6) begin
            n = $urandom_range(10, 1);
            repeat (n) send_req(random_line());
            send_req(ctl_req(OP_DUMP, $urandom));
            n = $urandom_range(3, 0);
            repeat (n) send_req(random_line());
            if ($urandom_range(3, 0) != 0) send_req(ctl_req(OP_DELETE, $urandom));
         end else if (pick == 7) begin
            n = $urandom_range(70, 20);
            repeat (n) send_req(random_line());
            send_req(ctl_req(OP_DUMP, $urandom));
         end else if (pick == 8) begin
            send_req(ctl_req(OP_DUMP, $urandom));
            send_req(ctl_req(OP_DUMP, $urandom));
            send_req(ctl_req(OP_DELETE, $urandom));
         end else begin
            n = $urandom_range(4, 1);
            repeat (n) begin
               r = random_line();
               r.op = 2'($urandom_range(3, 0));
               send_req(r);
            end
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow the block to settle
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d appends, %0d dumps, %0d deletes, %0d ignored items; %0d results checked",
               board.appends, board.dumps, board.deletes, board.ignored, board.checked);
      $display("longest dump %0d lines, %0d full-ring dumps, %0d marks lost to overwrite",
               board.longest_dump, board.full_dumps, board.mark_drops);
      if (board.failures == 0 && board.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/lrdp_pkg.sv
rtl/core/lrdp_store.sv
rtl/core/lrdp_ctrl.sv
rtl/core/log_ring_dump_prune.sv
bench/tb_log_ring_dump_prune.sv
